### rtl/core/urbd_pkg.sv
package urbd_pkg;

  // Sizes of the fields and of the internal state.
  localparam int TRIG_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int BAND_CM_W = 4;
  localparam int ECHO_W   = 16;
  localparam int DIST_W   = 11;
  localparam int LED_W    = 8;
  localparam int MODE_W   = 2;
  localparam int DIR_W    = 2;

  // Number of distance bands shown on the bar.
  localparam int NUM_BANDS = 8;
  localparam int BAND_W    = $clog2(NUM_BANDS);
  localparam int LIMIT_W   = 12;

  // Saturation value of the echo timer.
  localparam logic [ECHO_W-1:0] ECHO_MAX = '1;

  // Division by 58 as a multiply by round(2^21 / 58) and a shift by 21.
  localparam int                DIV_SHIFT = 21;
  localparam logic [ECHO_W-1:0] DIV58_MUL = 16'd36158;
  localparam int                PROD_W    = 2 * ECHO_W;

  // Mode codes.
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REV = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Motor direction codes.
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_CM       = 2'd2;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [TRIG_W-1:0]    TRIGGER_TICKS_RST = 8'd10;
  localparam logic [PERIOD_W-1:0]  PERIOD_TICKS_RST  = 16'd55296;
  localparam logic [BAND_CM_W-1:0] BAND_CM_RST       = 4'd3;

  // One classified tick on its way from the front to the back.
  typedef struct packed {
    logic              trig;
    logic              done;
    logic [ECHO_W-1:0] echo_width;
    logic [MODE_W-1:0] mode;
  } tick_t;

endpackage

### rtl/core/ultrasonic_ranger_bar_display_core.sv
// Ranger core: one tick in, one result out for each tick.
// A tick's result passes through the queue, the multiply stage and the output register.
// Throughput: one tick per cycle while the output side is ready; the two-entry queue
// and the output register let either side stall on its own.
// Reset (rst, synchronous, active high) clears all counters, mode and display state
// and loads the configuration defaults.
module ultrasonic_ranger_bar_display_core
  import urbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] echo_level, [1] button_press
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] trigger_out, [11:1] distance_cm, [12] measure_done, [20:13] led_bar,
  // [22:21] motor_dir
  output logic [23:0]           m_axis_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [TRIG_W-1:0]    trigger_ticks;
  logic [PERIOD_W-1:0]  period_ticks;
  logic [BAND_CM_W-1:0] band_cm;
  logic                 accept;
  logic                 q_not_full;
  logic                 q_not_empty;
  logic                 q_pop;
  tick_t                front_item;
  tick_t                q_head;
  logic                 trigger_out;
  logic [DIST_W-1:0]    distance_cm;
  logic                 measure_done;
  logic [LED_W-1:0]     led_bar;
  logic [DIR_W-1:0]     motor_dir;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= TRIGGER_TICKS_RST;
      period_ticks  <= PERIOD_TICKS_RST;
      band_cm       <= BAND_CM_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_TRIGGER_TICKS: trigger_ticks <= cfg_wdata[TRIG_W-1:0];
        REG_PERIOD_TICKS:  period_ticks  <= cfg_wdata[PERIOD_W-1:0];
        REG_BAND_CM:       band_cm       <= cfg_wdata[BAND_CM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input transfer whenever the queue has room.
  assign s_axis_tready = q_not_full;
  assign accept        = s_axis_tvalid && q_not_full;

  urbd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .echo_level    (s_axis_tdata[0]),
    .button_press  (s_axis_tdata[1]),
    .trigger_ticks (trigger_ticks),
    .period_ticks  (period_ticks),
    .item          (front_item)
  );

  urbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  urbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_not_empty),
    .head         (q_head),
    .pop          (q_pop),
    .band_cm      (band_cm),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .trigger_out  (trigger_out),
    .distance_cm  (distance_cm),
    .measure_done (measure_done),
    .led_bar      (led_bar),
    .motor_dir    (motor_dir)
  );

  // Result packing, first field in the lowest bits.
  assign m_axis_tdata = {1'b0, motor_dir, led_bar, measure_done, distance_cm, trigger_out};

endmodule

### rtl/core/urbd_front.sv
module urbd_front
  import urbd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                echo_level,
  input  logic                button_press,
  input  logic [TRIG_W-1:0]   trigger_ticks,
  input  logic [PERIOD_W-1:0] period_ticks,
  output tick_t               item
);

  logic [PERIOD_W-1:0] period_counter;
  logic [PERIOD_W-1:0] period_counter_next;
  logic                echo_active;
  logic                echo_active_next;
  logic [ECHO_W-1:0]   echo_width;
  logic [ECHO_W-1:0]   echo_width_next;
  logic [MODE_W-1:0]   mode_count;
  logic [MODE_W-1:0]   mode_count_next;
  logic                done;

  // Period counter and trigger level, taken before the counter advances.
  always_comb begin
    period_counter_next = period_counter + 1'b1;
    if (period_ticks != '0 && period_counter_next >= period_ticks) begin
      period_counter_next = '0;
    end
  end

  // Echo width timer, saturating, with the falling edge flagged.
  always_comb begin
    echo_active_next = echo_active;
    echo_width_next  = echo_width;
    done             = 1'b0;
    if (echo_level) begin
      if (!echo_active) begin
        echo_active_next = 1'b1;
        echo_width_next  = {{(ECHO_W-1){1'b0}}, 1'b1};
      end else if (echo_width != ECHO_MAX) begin
        echo_width_next = echo_width + 1'b1;
      end
    end else if (echo_active) begin
      echo_active_next = 1'b0;
      done             = 1'b1;
    end
  end

  // Mode sequence: off, forward, reverse, forward and so on.
  always_comb begin
    mode_count_next = mode_count;
    if (button_press) begin
      case (mode_count)
        MODE_OFF:    mode_count_next = MODE_FWD;
        MODE_FWD:    mode_count_next = MODE_REV;
        MODE_REV:    mode_count_next = MODE_FWD;
        MODE_UNUSED: mode_count_next = MODE_OFF;
        default:     mode_count_next = MODE_OFF;
      endcase
    end
  end

  // The item carries the width as it stood when the echo fell.
  always_comb begin
    item.trig       = ({{(PERIOD_W-TRIG_W){1'b0}}, trigger_ticks} > period_counter);
    item.done       = done;
    item.echo_width = echo_width;
    item.mode       = mode_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counter <= '0;
      echo_active    <= 1'b0;
      echo_width     <= '0;
      mode_count     <= MODE_OFF;
    end else if (accept) begin
      period_counter <= period_counter_next;
      echo_active    <= echo_active_next;
      echo_width     <= echo_width_next;
      mode_count     <= mode_count_next;
    end
  end

endmodule

### rtl/core/urbd_queue.sv
module urbd_queue
  import urbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  tick_t push_item,
  output logic  not_full,
  input  logic  pop,
  output logic  not_empty,
  output tick_t head
);

  tick_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  // Two-entry queue; a push and a pop may share a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/core/urbd_back.sv
module urbd_back
  import urbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  tick_t                head,
  output logic                 pop,
  input  logic [BAND_CM_W-1:0] band_cm,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 trigger_out,
  output logic [DIST_W-1:0]    distance_cm,
  output logic                 measure_done,
  output logic [LED_W-1:0]     led_bar,
  output logic [DIR_W-1:0]     motor_dir
);

  logic                 s1_valid;
  tick_t                s1_item;
  logic [PROD_W-1:0]    s1_prod;
  logic                 s2_take;
  logic                 s1_take;
  logic [DIST_W-1:0]    distance_reg;
  logic [DIST_W-1:0]    distance_next;
  logic [LED_W-1:0]     led_reg;
  logic [LED_W-1:0]     led_next;
  logic [DIR_W-1:0]     dir_reg;
  logic [DIR_W-1:0]     dir_next;
  logic [BAND_CM_W-1:0] width;
  logic [BAND_W-1:0]    band;
  logic                 in_range;
  logic [3:0]           lit;
  logic                 trig_reg;
  logic                 done_reg;

  // Pipeline flow: the output register frees up, then stage one moves.
  assign s2_take = s1_valid && (!out_valid || out_ready);
  assign s1_take = !s1_valid || s2_take;
  assign pop     = head_valid && s1_take;

  // Stage one: multiply by the reciprocal of 58.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item <= head;
      s1_prod <= head.echo_width * DIV58_MUL;
    end
  end

  // New distance on a completed measurement.
  assign distance_next = s1_item.done ? s1_prod[DIV_SHIFT +: DIST_W] : distance_reg;

  // Band index by comparing against each band boundary.
  always_comb begin
    width = (band_cm == '0) ? {{(BAND_CM_W-1){1'b0}}, 1'b1} : band_cm;
    in_range = ({1'b0, distance_next}
                < LIMIT_W'(NUM_BANDS) * {{(LIMIT_W-BAND_CM_W){1'b0}}, width});
    band = '0;
    for (int k = 1; k < NUM_BANDS; k++) begin
      if ({1'b0, distance_next} >= LIMIT_W'(k) * {{(LIMIT_W-BAND_CM_W){1'b0}}, width}) begin
        band = band + 1'b1;
      end
    end
  end

  // Bar pattern and motor direction for the band.
  always_comb begin
    lit = (5'(band) + 5'd1 > 5'd8) ? 4'd8 : 4'(5'(band) + 5'd1);
    led_next = led_reg;
    dir_next = dir_reg;
    if (in_range) begin
      case (s1_item.mode)
        MODE_FWD: begin
          led_next = LED_W'(16'h00FF >> (4'd8 - lit));
          dir_next = DIR_FWD;
        end
        MODE_REV: begin
          led_next = LED_W'(16'hFF00 >> lit);
          dir_next = DIR_REV;
        end
        default: begin
          led_next = led_reg;
          dir_next = dir_reg;
        end
      endcase
    end
  end

  // Output register; it also holds the display state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      distance_reg <= '0;
      led_reg      <= '0;
      dir_reg      <= DIR_STOP;
    end else begin
      if (s2_take) begin
        out_valid    <= 1'b1;
        distance_reg <= distance_next;
        led_reg      <= led_next;
        dir_reg      <= dir_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      trig_reg <= s1_item.trig;
      done_reg <= s1_item.done;
    end
  end

  assign trigger_out  = trig_reg;
  assign measure_done = done_reg;
  assign distance_cm  = distance_reg;
  assign led_bar      = led_reg;
  assign motor_dir    = dir_reg;

endmodule

### test/ultrasonic_ranger_bar_display_core_tb.sv
module ultrasonic_ranger_bar_display_core_tb;
  import urbd_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int CM_TICKS       = 58;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 2000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One result as the block should present it.
  typedef struct packed {
    logic              trig;
    logic [DIST_W-1:0] distance;
    logic              done;
    logic [LED_W-1:0]  led;
    logic [DIR_W-1:0]  dir;
  } range_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [0] echo_level, [1] button_press
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [0] trigger_out, [11:1] distance_cm, [12] measure_done, [20:13] led_bar,
  // [22:21] motor_dir
  logic [23:0]           m_axis_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predicted configuration and state of the ranger.
  logic [TRIG_W-1:0]    trig_ticks;
  logic [PERIOD_W-1:0]  period_len;
  logic [BAND_CM_W-1:0] band_width;
  logic [PERIOD_W-1:0]  period_cnt;
  logic                 echo_busy;
  logic [ECHO_W-1:0]    echo_len;
  logic [DIST_W-1:0]    range_cm;
  logic [MODE_W-1:0]    mode_sel;
  logic [LED_W-1:0]     led_lit;
  logic [DIR_W-1:0]     motor_dir;

  range_result_t expected_results[$];
  int errors;
  int results_seen;
  int ticks_sent;
  int src_idle_pct;
  int sink_idle_pct;

  ultrasonic_ranger_bar_display_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Advance the predicted state by one tick and return the result it gives.
  function automatic range_result_t predict_tick(logic echo, logic press);
    range_result_t       r;
    logic [PERIOD_W-1:0] nxt;
    int unsigned         width;
    int unsigned         band;
    int unsigned         lit;
    r = '0;

    // The trigger level comes from the counter before it moves on.
    r.trig = (period_cnt < PERIOD_W'(trig_ticks));
    nxt = period_cnt + 1'b1;
    if (period_len != '0 && nxt >= period_len) begin
      nxt = '0;
    end
    period_cnt = nxt;

    // Echo width timing; the falling edge completes a measurement.
    if (echo) begin
      if (!echo_busy) begin
        echo_busy = 1'b1;
        echo_len  = ECHO_W'(1);
      end else if (echo_len != ECHO_MAX) begin
        echo_len = echo_len + 1'b1;
      end
    end else if (echo_busy) begin
      range_cm  = DIST_W'(echo_len / CM_TICKS);
      echo_busy = 1'b0;
      r.done    = 1'b1;
    end

    // Each press steps off, forward, reverse, forward and so on.
    if (press) begin
      mode_sel = mode_sel + 1'b1;
      if (mode_sel > MODE_REV) begin
        mode_sel = MODE_FWD;
      end
    end

    // Band lookup with the distance of this very tick.
    width = (band_width == '0) ? 1 : band_width;
    band  = range_cm / width;
    if ((mode_sel == MODE_FWD || mode_sel == MODE_REV) && band < NUM_BANDS) begin
      lit = (band + 1 > LED_W) ? LED_W : band + 1;
      if (mode_sel == MODE_FWD) begin
        led_lit   = LED_W'((32'd1 << lit) - 1);
        motor_dir = DIR_FWD;
      end else begin
        led_lit   = LED_W'((32'hFF << (LED_W - lit)) & 32'hFF);
        motor_dir = DIR_REV;
      end
    end

    r.distance = range_cm;
    r.led      = led_lit;
    r.dir      = motor_dir;
    return r;
  endfunction

  function automatic logic maybe_press(int unsigned one_in);
    return one_in != 0 && $urandom_range(one_in - 1) == 0;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s got %0d expected %0d",
                             results_seen, name, got, want));
    end
  endtask

  // Offer one tick to the block and record its expected result once it transfers.
  task automatic send_tick(input logic echo, input logic press);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, press, echo};
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(predict_tick(echo, press));
    ticks_sent++;
  endtask

  // An echo held high for the given ticks, then the low tick that ends it.
  task automatic send_echo(input int unsigned high_ticks, input int unsigned press_one_in);
    repeat (high_ticks) send_tick(1'b1, maybe_press(press_one_in));
    send_tick(1'b0, maybe_press(press_one_in));
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic wait_results_done();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_TRIGGER_TICKS: trig_ticks = TRIG_W'(value);
      REG_PERIOD_TICKS:  period_len = PERIOD_W'(value);
      REG_BAND_CM:       band_width = BAND_CM_W'(value);
      default: ;
    endcase
  endtask

  // Trigger window, period wrap and the off mode holding the display.
  task automatic test_trigger_timing();
    repeat (12) send_tick(1'b0, 1'b0);
    // A measurement in off mode leaves the bar dark.
    send_echo(60, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    wait_results_done();
    write_reg(REG_TRIGGER_TICKS, 3);
    write_reg(REG_PERIOD_TICKS, 16);
    repeat (36) send_tick(1'($urandom_range(1)), 1'b0);
    // A trigger longer than the period keeps the line high.
    wait_results_done();
    write_reg(REG_TRIGGER_TICKS, 255);
    repeat (20) send_tick(1'b0, 1'b0);
    // A zero period lets the counter run the full 16-bit range.
    wait_results_done();
    write_reg(REG_TRIGGER_TICKS, 1);
    write_reg(REG_PERIOD_TICKS, 0);
    repeat (20) send_tick(1'b0, 1'b0);
    wait_results_done();
    write_reg(REG_PERIOD_TICKS, 65535);
    repeat (10) send_tick(1'b0, 1'b0);
  endtask

  // Band boundaries in both directions and the hold beyond the last band.
  task automatic test_mode_bands();
    wait_results_done();
    write_reg(REG_TRIGGER_TICKS, 10);
    write_reg(REG_PERIOD_TICKS, 1000);
    write_reg(REG_BAND_CM, 1);
    while (mode_sel != MODE_FWD) send_tick(1'b0, 1'b1);
    // Top of the first band, bottom of the second, then past the last band.
    send_echo(CM_TICKS - 1, 0);
    send_tick(1'b0, 1'b0);
    send_echo(CM_TICKS, 0);
    send_tick(1'b0, 1'b0);
    send_echo(CM_TICKS * NUM_BANDS, 0);
    send_tick(1'b0, 1'b0);
    // Reverse fill with a zero band width, which acts as one centimetre.
    wait_results_done();
    write_reg(REG_BAND_CM, 0);
    send_tick(1'b0, 1'b1);
    send_echo(CM_TICKS + 3, 0);
    send_tick(1'b0, 1'b0);
    send_echo(3, 0);
    send_tick(1'b0, 1'b0);
    // A press on the falling-edge tick picks the new mode for that band.
    repeat (60) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  // Mostly clean echo pulses with random gaps and presses, some line noise.
  task automatic random_burst(input int unsigned n);
    int unsigned stop_at;
    int unsigned half_way;
    int unsigned cm;
    bit          paused;
    stop_at  = ticks_sent + n;
    half_way = ticks_sent + n / 2;
    paused   = 1'b0;
    while (ticks_sent < stop_at) begin
      if (!paused && ticks_sent >= half_way) begin
        wait_results_done();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 70) begin
        cm = ($urandom_range(99) < 85) ? $urandom_range(0, 2) : $urandom_range(3, 9);
        repeat ($urandom_range(1, 8)) send_tick(1'b0, maybe_press(20));
        send_echo(CM_TICKS * cm + $urandom_range(1, CM_TICKS - 1), 20);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  // Three random phases, each with its own settings and idling pattern.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      wait_results_done();
      case (phase)
        0: begin
          write_reg(REG_TRIGGER_TICKS, $urandom_range(1, 40));
          write_reg(REG_PERIOD_TICKS, $urandom_range(16, 200));
          write_reg(REG_BAND_CM, 1);
        end
        1: begin
          src_idle_pct  = 68;
          sink_idle_pct = 19;
          write_reg(REG_TRIGGER_TICKS, 255);
          write_reg(REG_PERIOD_TICKS, 65535);
          write_reg(REG_BAND_CM, 2);
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
          write_reg(REG_TRIGGER_TICKS, $urandom_range(1, 20));
          write_reg(REG_PERIOD_TICKS, 16);
          write_reg(REG_BAND_CM, $urandom_range(1, 3));
        end
      endcase
      random_burst(100);
    end
  endtask

  // Widest band, a write to an unused register index and a short period.
  task automatic test_wide_band();
    wait_results_done();
    write_reg(REG_BAND_CM, 15);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_PERIOD_TICKS, 400);
    while (mode_sel != MODE_FWD) send_tick(1'b0, 1'b1);
    send_echo(CM_TICKS + 10, 0);
    repeat (4) send_tick(1'b0, 1'b0);
  endtask

  // The sink stalls at random at the configured rate.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    range_result_t want;
    range_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.trig     = m_axis_tdata[0];
      got.distance = m_axis_tdata[11:1];
      got.done     = m_axis_tdata[12];
      got.led      = m_axis_tdata[20:13];
      got.dir      = m_axis_tdata[22:21];
      if (expected_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        compare_field("trigger_out", got.trig, want.trig);
        compare_field("distance_cm", got.distance, want.distance);
        compare_field("measure_done", got.done, want.done);
        compare_field("led_bar", got.led, want.led);
        compare_field("motor_dir", got.dir, want.dir);
      end
      results_seen++;
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    trig_ticks    = TRIGGER_TICKS_RST;
    period_len    = PERIOD_TICKS_RST;
    band_width    = BAND_CM_RST;
    period_cnt    = '0;
    echo_busy     = 1'b0;
    echo_len      = '0;
    range_cm      = '0;
    mode_sel      = MODE_OFF;
    led_lit       = '0;
    motor_dir     = DIR_STOP;
    errors        = 0;
    results_seen  = 0;
    ticks_sent    = 0;
    src_idle_pct  = 19;
    sink_idle_pct = 68;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_trigger_timing();
    test_mode_bands();
    test_random_traffic();
    test_wide_band();

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule
